@@ hdl/mdte_pkg.sv @@
// shared constants, types and helper functions of the md tag event encoder
// no dependencies
`timescale 1ns / 1ps

package mdte_pkg;

   // longest deletion run that is buffered
   localparam int MAX_DELETION_BASES = 64;
   // results kept per input item
   localparam int RESULT_CAP = 40;

   localparam int DEL_LEN_W  = $clog2(MAX_DELETION_BASES + 1);
   // deletion codes are stored two to an entry, first code in the high nibble
   localparam int DEL_DEPTH  = (MAX_DELETION_BASES + 1) / 2;
   localparam int DEL_ADDR_W = (DEL_DEPTH > 1) ? $clog2(DEL_DEPTH) : 1;
   localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

   localparam logic [15:0] EVENT_MAX = 16'hFFFF;
   localparam logic [16:0] BYTE_SAT  = 17'h1FFFF;

   localparam logic [7:0] EV_MATCH    = 8'd0;
   localparam logic [7:0] EV_MISMATCH = 8'd1;
   localparam logic [7:0] EV_DELETION = 8'd2;

   localparam logic [7:0] ASCII_0       = 8'h30;
   localparam logic [7:0] ASCII_9       = 8'h39;
   localparam logic [7:0] ASCII_CARET   = 8'h5E;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [7:0] ASCII_CASE    = 8'h20;

   // iupac code table "=ACMGRSVTWYHKDBN", index is the code
   localparam logic [7:0] CODE_TABLE [16] = '{
      8'h3D, 8'h41, 8'h43, 8'h4D, 8'h47, 8'h52, 8'h53, 8'h56,
      8'h54, 8'h57, 8'h59, 8'h48, 8'h4B, 8'h44, 8'h42, 8'h4E
   };
   localparam logic [4:0] CODE_NONE = 5'd16;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_MATCH,
      MODE_DELETION
   } mode_type;

   typedef enum logic [1:0] {
      CH_DIGIT,
      CH_CARET,
      CH_LETTER,
      CH_OTHER
   } char_kind_type;

   typedef enum logic [2:0] {
      ERR_OK,
      ERR_MATCH_OVF,
      ERR_DEL_LEN,
      ERR_DEL_BASE,
      ERR_MIS_BASE,
      ERR_BAD_CHAR,
      ERR_COUNT_OVF,
      ERR_PAYLOAD_OVF
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAIN,
      ST_MIS_TYPE,
      ST_MIS_CODE,
      ST_MF_CHK,
      ST_MF_BYTE,
      ST_DF_CHK,
      ST_DF_HDR,
      ST_DF_RD,
      ST_DF_EMIT,
      ST_ERR,
      ST_FILL,
      ST_MARK
   } fsm_type;

   // sequencer to output buffer
   typedef struct packed {
      logic        put;
      logic [7:0]  data;
      logic        fin;
      logic        mark;
      err_type     code;
      logic [15:0] ev_total;
      logic [15:0] pay_total;
   } cmd_type;

   // output buffer to sequencer
   typedef struct packed {
      logic put_ok;
      logic fin_ok;
      logic any_res;
   } stat_type;

   function automatic char_kind_type kind_of(input logic [7:0] c);
      char_kind_type k;
      if (c >= ASCII_0 && c <= ASCII_9) begin
         k = CH_DIGIT;
      end else if (c == ASCII_CARET) begin
         k = CH_CARET;
      end else if ((c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) ||
                   (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)) begin
         k = CH_LETTER;
      end else begin
         k = CH_OTHER;
      end
      return k;
   endfunction

   // code of a letter, CODE_NONE when it is not in the table
   function automatic logic [4:0] code_of(input logic [7:0] c);
      logic [7:0] u;
      logic [4:0] code;
      u = (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) ? c - ASCII_CASE : c;
      code = CODE_NONE;
      for (int i = 0; i < 16; i++) begin
         if (CODE_TABLE[i] == u) begin
            code = 5'(i);
         end
      end
      return code;
   endfunction

endpackage

@@ hdl/mdte_req_if.sv @@
// input channel of the md tag event encoder: one tag character per item
// no dependencies
`timescale 1ns / 1ps

interface mdte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last_char;

   modport source (output valid, output char_in, output last_char, input ready);
   modport sink (input valid, input char_in, input last_char, output ready);
endinterface

@@ hdl/mdte_rsp_if.sv @@
// result channel of the md tag event encoder: one payload byte per item
// no dependencies
`timescale 1ns / 1ps

interface mdte_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        run_last;
   logic        string_done;
   logic [2:0]  error_code;
   logic [15:0] event_total;
   logic [15:0] payload_total;

   modport source (
      output valid, output out_byte, output run_last, output string_done,
      output error_code, output event_total, output payload_total, input ready
   );
   modport sink (
      input valid, input out_byte, input run_last, input string_done,
      input error_code, input event_total, input payload_total, output ready
   );
endinterface

@@ hdl/mdte_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module mdte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // read data holds while re is low
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/mdte_obuf.sv @@
// result buffer: one held-back result, the output register and the per item cap
// depends on mdte_pkg and mdte_rsp_if
`timescale 1ns / 1ps

module mdte_obuf (
   input  logic               clock,
   input  logic               reset,
   input  mdte_pkg::cmd_type  cmd,
   output mdte_pkg::stat_type stat,
   mdte_rsp_if.source         rsp
);

   logic                           pend_v_ff, pend_v_in;
   logic [7:0]                     pend_byte_ff, pend_byte_in;
   logic [mdte_pkg::RES_CNT_W-1:0] cnt_ff, cnt_in;

   logic                           out_v_ff, out_v_in;
   logic [7:0]                     out_byte_ff, out_byte_in;
   logic                           out_rl_ff, out_rl_in;
   logic                           out_done_ff, out_done_in;
   mdte_pkg::err_type              out_code_ff, out_code_in;
   logic [15:0]                    out_ev_ff, out_ev_in;
   logic [15:0]                    out_pay_ff, out_pay_in;

   logic out_free;
   logic capped;

   assign out_free = !out_v_ff || rsp.ready;
   // results past the cap are dropped, the held one then takes the final marks
   assign capped   = cnt_ff >= mdte_pkg::RES_CNT_W'(mdte_pkg::RESULT_CAP);

   assign stat.put_ok  = capped || !pend_v_ff || out_free;
   assign stat.fin_ok  = !pend_v_ff || out_free;
   assign stat.any_res = cnt_ff != '0;

   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_byte_in = pend_byte_ff;
      cnt_in       = cnt_ff;
      out_v_in     = out_v_ff && !rsp.ready;
      out_byte_in  = out_byte_ff;
      out_rl_in    = out_rl_ff;
      out_done_in  = out_done_ff;
      out_code_in  = out_code_ff;
      out_ev_in    = out_ev_ff;
      out_pay_in   = out_pay_ff;

      if (cmd.put && stat.put_ok && !capped) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_byte_in = pend_byte_ff;
            out_rl_in   = 1'b0;
            out_done_in = 1'b0;
            out_code_in = mdte_pkg::ERR_OK;
            out_ev_in   = '0;
            out_pay_in  = '0;
         end
         pend_v_in    = 1'b1;
         pend_byte_in = cmd.data;
         cnt_in       = cnt_ff + 1'b1;
      end else if (cmd.fin && stat.fin_ok) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_byte_in = pend_byte_ff;
            out_rl_in   = 1'b1;
            out_done_in = cmd.mark;
            out_code_in = cmd.mark ? cmd.code : mdte_pkg::ERR_OK;
            out_ev_in   = cmd.mark ? cmd.ev_total : 16'd0;
            out_pay_in  = cmd.mark ? cmd.pay_total : 16'd0;
         end
         pend_v_in = 1'b0;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         cnt_ff    <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         cnt_ff    <= cnt_in;
         out_v_ff  <= out_v_in;
      end
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_rl_ff    <= out_rl_in;
      out_done_ff  <= out_done_in;
      out_code_ff  <= out_code_in;
      out_ev_ff    <= out_ev_in;
      out_pay_ff   <= out_pay_in;
   end

   assign rsp.valid         = out_v_ff;
   assign rsp.out_byte      = out_byte_ff;
   assign rsp.run_last      = out_rl_ff;
   assign rsp.string_done   = out_done_ff;
   assign rsp.error_code    = out_code_ff;
   assign rsp.event_total   = out_ev_ff;
   assign rsp.payload_total = out_pay_ff;

endmodule

@@ hdl/mdte_seq.sv @@
// parse sequencer: tag state, deletion buffer access and event byte generation
// depends on mdte_pkg and mdte_req_if
`timescale 1ns / 1ps

module mdte_seq (
   input  logic                            clock,
   input  logic                            reset,
   mdte_req_if.sink                        req,
   output mdte_pkg::cmd_type               cmd,
   input  mdte_pkg::stat_type              stat,
   output logic                            ram_we,
   output logic [mdte_pkg::DEL_ADDR_W-1:0] ram_waddr,
   output logic [7:0]                      ram_wdata,
   output logic                            ram_re,
   output logic [mdte_pkg::DEL_ADDR_W-1:0] ram_raddr,
   input  logic [7:0]                      ram_rdata
);

   localparam int LW = mdte_pkg::DEL_LEN_W;

   mdte_pkg::fsm_type       state_ff, state_in;
   mdte_pkg::mode_type      mode_ff, mode_in;
   logic [31:0]             acc_ff, acc_in;
   logic [LW-1:0]           dlen_ff, dlen_in;
   logic                    dbad_ff, dbad_in;
   logic [3:0]              prev_code_ff, prev_code_in;
   logic [15:0]             ev_ff, ev_in;
   logic [16:0]             bc_ff, bc_in;
   logic                    disc_ff, disc_in;

   mdte_pkg::char_kind_type kind_ff, kind_in;
   logic [4:0]              val_ff, val_in;
   logic                    last_ff, last_in;
   logic                    post_ff, post_in;
   logic [2:0]              idx_ff, idx_in;
   logic [LW-1:0]           pk_ff, pk_in;
   mdte_pkg::err_type       err_ff, err_in;
   logic                    mark_ff, mark_in;

   logic                    in_ready;
   logic                    clear_str;
   logic                    count_byte;
   logic [31:0]             acc_base;
   logic [35:0]             acc_next;
   logic [15:0]             dlen_wide;
   logic [LW-1:0]           dlen_half;
   logic [LW-1:0]           pk_next;
   logic                    more_pairs;
   logic [3:0]              code4;
   logic [15:0]             pay_total;
   mdte_pkg::char_kind_type in_kind;

   assign req.ready = in_ready;
   assign in_kind   = mdte_pkg::kind_of(req.char_in);

   // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
   assign acc_base  = (mode_ff == mdte_pkg::MODE_MATCH) ? acc_ff : 32'd0;
   assign acc_next  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                    + {32'd0, val_ff[3:0]};
   assign dlen_wide = 16'(dlen_ff);
   assign dlen_half = dlen_ff >> 1;
   assign pk_next   = pk_ff + 1'b1;
   assign more_pairs = {pk_next, 1'b0} < {1'b0, dlen_ff};
   assign code4     = val_ff[4] ? 4'd0 : val_ff[3:0];
   assign pay_total = bc_ff[16] ? 16'hFFFF : bc_ff[15:0];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      dlen_in      = dlen_ff;
      dbad_in      = dbad_ff;
      prev_code_in = prev_code_ff;
      ev_in        = ev_ff;
      bc_in        = bc_ff;
      disc_in      = disc_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      post_in      = post_ff;
      idx_in       = idx_ff;
      pk_in        = pk_ff;
      err_in       = err_ff;
      mark_in      = mark_ff;

      in_ready   = 1'b0;
      clear_str  = 1'b0;
      count_byte = 1'b0;
      cmd        = '0;
      ram_we     = 1'b0;
      ram_waddr  = dlen_half[mdte_pkg::DEL_ADDR_W-1:0];
      ram_wdata  = dlen_ff[0] ? {prev_code_ff, code4} : {code4, 4'd0};
      ram_re     = 1'b0;
      ram_raddr  = pk_ff[mdte_pkg::DEL_ADDR_W-1:0];

      unique case (state_ff)
         mdte_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (req.valid) begin
               if (disc_ff) begin
                  // rest of a failed string, dropped up to its last character
                  if (req.last_char) begin
                     disc_in   = 1'b0;
                     clear_str = 1'b1;
                  end
               end else begin
                  kind_in = in_kind;
                  last_in = req.last_char;
                  post_in = 1'b0;
                  mark_in = 1'b0;
                  unique case (in_kind)
                     mdte_pkg::CH_DIGIT:  val_in = {1'b0, req.char_in[3:0]};
                     mdte_pkg::CH_LETTER: val_in = mdte_pkg::code_of(req.char_in);
                     mdte_pkg::CH_CARET,
                     mdte_pkg::CH_OTHER:  val_in = 5'd0;
                  endcase
                  // close a pending event that this character cannot extend
                  priority if (in_kind == mdte_pkg::CH_DIGIT &&
                               mode_ff == mdte_pkg::MODE_DELETION) begin
                     state_in = mdte_pkg::ST_DF_CHK;
                  end else if (in_kind == mdte_pkg::CH_CARET &&
                               mode_ff == mdte_pkg::MODE_DELETION) begin
                     state_in = mdte_pkg::ST_DF_CHK;
                  end else if ((in_kind == mdte_pkg::CH_CARET ||
                                in_kind == mdte_pkg::CH_LETTER) &&
                               mode_ff == mdte_pkg::MODE_MATCH) begin
                     state_in = mdte_pkg::ST_MF_CHK;
                  end else begin
                     state_in = mdte_pkg::ST_MAIN;
                  end
               end
            end
         end

         mdte_pkg::ST_MAIN: begin
            unique case (kind_ff)
               mdte_pkg::CH_DIGIT: begin
                  if (acc_next[35:32] != 4'd0) begin
                     err_in   = mdte_pkg::ERR_MATCH_OVF;
                     state_in = mdte_pkg::ST_ERR;
                  end else begin
                     acc_in  = acc_next[31:0];
                     mode_in = mdte_pkg::MODE_MATCH;
                     if (last_ff) begin
                        post_in  = 1'b1;
                        state_in = mdte_pkg::ST_MF_CHK;
                     end else begin
                        state_in = stat.any_res ? mdte_pkg::ST_MARK : mdte_pkg::ST_IDLE;
                     end
                  end
               end
               mdte_pkg::CH_CARET: begin
                  mode_in = mdte_pkg::MODE_DELETION;
                  dlen_in = '0;
                  dbad_in = 1'b0;
                  if (last_ff) begin
                     post_in  = 1'b1;
                     state_in = mdte_pkg::ST_DF_CHK;
                  end else begin
                     state_in = stat.any_res ? mdte_pkg::ST_MARK : mdte_pkg::ST_IDLE;
                  end
               end
               mdte_pkg::CH_LETTER: begin
                  if (mode_ff == mdte_pkg::MODE_DELETION) begin
                     if (dlen_ff >= LW'(mdte_pkg::MAX_DELETION_BASES)) begin
                        err_in   = mdte_pkg::ERR_DEL_LEN;
                        state_in = mdte_pkg::ST_ERR;
                     end else begin
                        // odd positions complete the pair started before
                        ram_we       = 1'b1;
                        prev_code_in = code4;
                        dbad_in      = dbad_ff | val_ff[4];
                        dlen_in      = dlen_ff + 1'b1;
                        if (last_ff) begin
                           post_in  = 1'b1;
                           state_in = mdte_pkg::ST_DF_CHK;
                        end else begin
                           state_in = stat.any_res ? mdte_pkg::ST_MARK : mdte_pkg::ST_IDLE;
                        end
                     end
                  end else if (val_ff[4]) begin
                     err_in   = mdte_pkg::ERR_MIS_BASE;
                     state_in = mdte_pkg::ST_ERR;
                  end else if (ev_ff == mdte_pkg::EVENT_MAX) begin
                     err_in   = mdte_pkg::ERR_COUNT_OVF;
                     state_in = mdte_pkg::ST_ERR;
                  end else begin
                     ev_in    = ev_ff + 1'b1;
                     state_in = mdte_pkg::ST_MIS_TYPE;
                  end
               end
               mdte_pkg::CH_OTHER: begin
                  err_in   = mdte_pkg::ERR_BAD_CHAR;
                  state_in = mdte_pkg::ST_ERR;
               end
            endcase
         end

         mdte_pkg::ST_MIS_TYPE: begin
            cmd.put  = 1'b1;
            cmd.data = mdte_pkg::EV_MISMATCH;
            if (stat.put_ok) begin
               count_byte = 1'b1;
               state_in   = mdte_pkg::ST_MIS_CODE;
            end
         end

         mdte_pkg::ST_MIS_CODE: begin
            cmd.put  = 1'b1;
            cmd.data = {4'd0, val_ff[3:0]};
            if (stat.put_ok) begin
               count_byte = 1'b1;
               state_in   = last_ff ? mdte_pkg::ST_FILL : mdte_pkg::ST_MARK;
            end
         end

         mdte_pkg::ST_MF_CHK: begin
            if (ev_ff == mdte_pkg::EVENT_MAX) begin
               err_in   = mdte_pkg::ERR_COUNT_OVF;
               state_in = mdte_pkg::ST_ERR;
            end else begin
               ev_in    = ev_ff + 1'b1;
               idx_in   = 3'd0;
               state_in = mdte_pkg::ST_MF_BYTE;
            end
         end

         mdte_pkg::ST_MF_BYTE: begin
            cmd.put = 1'b1;
            unique case (idx_ff)
               3'd0:    cmd.data = mdte_pkg::EV_MATCH;
               3'd1:    cmd.data = acc_ff[7:0];
               3'd2:    cmd.data = acc_ff[15:8];
               3'd3:    cmd.data = acc_ff[23:16];
               default: cmd.data = acc_ff[31:24];
            endcase
            if (stat.put_ok) begin
               count_byte = 1'b1;
               idx_in     = idx_ff + 1'b1;
               if (idx_ff == 3'd4) begin
                  mode_in  = mdte_pkg::MODE_IDLE;
                  state_in = post_ff ? mdte_pkg::ST_FILL : mdte_pkg::ST_MAIN;
               end
            end
         end

         mdte_pkg::ST_DF_CHK: begin
            priority if (dlen_ff == '0) begin
               err_in   = mdte_pkg::ERR_DEL_LEN;
               state_in = mdte_pkg::ST_ERR;
            end else if (dbad_ff) begin
               err_in   = mdte_pkg::ERR_DEL_BASE;
               state_in = mdte_pkg::ST_ERR;
            end else if (ev_ff == mdte_pkg::EVENT_MAX) begin
               err_in   = mdte_pkg::ERR_COUNT_OVF;
               state_in = mdte_pkg::ST_ERR;
            end else begin
               ev_in    = ev_ff + 1'b1;
               idx_in   = 3'd0;
               state_in = mdte_pkg::ST_DF_HDR;
            end
         end

         mdte_pkg::ST_DF_HDR: begin
            cmd.put = 1'b1;
            unique case (idx_ff)
               3'd0:    cmd.data = mdte_pkg::EV_DELETION;
               3'd1:    cmd.data = dlen_wide[7:0];
               default: cmd.data = dlen_wide[15:8];
            endcase
            if (stat.put_ok) begin
               count_byte = 1'b1;
               idx_in     = idx_ff + 1'b1;
               if (idx_ff == 3'd2) begin
                  pk_in    = '0;
                  state_in = mdte_pkg::ST_DF_RD;
               end
            end
         end

         mdte_pkg::ST_DF_RD: begin
            ram_re   = 1'b1;
            state_in = mdte_pkg::ST_DF_EMIT;
         end

         mdte_pkg::ST_DF_EMIT: begin
            cmd.put  = 1'b1;
            cmd.data = ram_rdata;
            if (stat.put_ok) begin
               count_byte = 1'b1;
               pk_in      = pk_next;
               if (more_pairs) begin
                  state_in = mdte_pkg::ST_DF_RD;
               end else begin
                  mode_in  = mdte_pkg::MODE_IDLE;
                  dlen_in  = '0;
                  state_in = post_ff ? mdte_pkg::ST_FILL : mdte_pkg::ST_MAIN;
               end
            end
         end

         mdte_pkg::ST_ERR: begin
            cmd.put  = 1'b1;
            cmd.data = 8'd0;
            if (stat.put_ok) begin
               mark_in  = 1'b1;
               state_in = mdte_pkg::ST_MARK;
            end
         end

         mdte_pkg::ST_FILL: begin
            // a string that ends without a byte still gets one closing result
            mark_in = 1'b1;
            err_in  = bc_ff[16] ? mdte_pkg::ERR_PAYLOAD_OVF : mdte_pkg::ERR_OK;
            if (stat.any_res) begin
               state_in = mdte_pkg::ST_MARK;
            end else begin
               cmd.put  = 1'b1;
               cmd.data = 8'd0;
               if (stat.put_ok) begin
                  state_in = mdte_pkg::ST_MARK;
               end
            end
         end

         mdte_pkg::ST_MARK: begin
            cmd.fin       = 1'b1;
            cmd.mark      = mark_ff;
            cmd.code      = err_ff;
            cmd.ev_total  = ev_ff;
            cmd.pay_total = pay_total;
            if (stat.fin_ok) begin
               if (mark_ff) begin
                  clear_str = 1'b1;
                  disc_in   = !last_ff;
               end
               state_in = mdte_pkg::ST_IDLE;
            end
         end

         default: state_in = mdte_pkg::ST_IDLE;
      endcase

      if (count_byte && bc_ff != mdte_pkg::BYTE_SAT) begin
         bc_in = bc_ff + 1'b1;
      end

      if (clear_str) begin
         mode_in = mdte_pkg::MODE_IDLE;
         acc_in  = '0;
         dlen_in = '0;
         dbad_in = 1'b0;
         ev_in   = '0;
         bc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdte_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mdte_pkg::MODE_IDLE;
         acc_ff  <= '0;
         dlen_ff <= '0;
         dbad_ff <= 1'b0;
         ev_ff   <= '0;
         bc_ff   <= '0;
         disc_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         dlen_ff <= dlen_in;
         dbad_ff <= dbad_in;
         ev_ff   <= ev_in;
         bc_ff   <= bc_in;
         disc_ff <= disc_in;
      end
      prev_code_ff <= prev_code_in;
      kind_ff      <= kind_in;
      val_ff       <= val_in;
      last_ff      <= last_in;
      post_ff      <= post_in;
      idx_ff       <= idx_in;
      pk_ff        <= pk_in;
      err_ff       <= err_in;
      mark_ff      <= mark_in;
   end

endmodule

@@ hdl/md_tag_event_encoder_top.sv @@
// md tag event encoder top: characters in, event bytes out; built from mdte_seq, mdte_ram, mdte_obuf
// steps: a character is taken in idle and decoded in main (a discarded one is only taken); match,
//   mismatch, deletion header and error bytes are put one by one, each packed deletion byte after a
//   ram read; flushes begin with a check; a fill step ends a tag; a closing step follows any results
// reset: synchronous, clears parse state and output valid; the deletion ram is not cleared
`timescale 1ns / 1ps

module md_tag_event_encoder_top (
   input logic        clock,
   input logic        reset,
   mdte_req_if.sink   req_ch,
   mdte_rsp_if.source rsp_ch
);

   // sequencer to result buffer
   mdte_pkg::cmd_type  cmd;
   mdte_pkg::stat_type stat;

   // deletion code buffer, two codes per entry
   logic                            ram_we;
   logic [mdte_pkg::DEL_ADDR_W-1:0] ram_waddr;
   logic [7:0]                      ram_wdata;
   logic                            ram_re;
   logic [mdte_pkg::DEL_ADDR_W-1:0] ram_raddr;
   logic [7:0]                      ram_rdata;

   // parser: owns match accumulator, deletion length and counters,
   // walks each character through flush, update and closing steps
   mdte_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd       (cmd),
      .stat      (stat),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // packed deletion codes, written while letters arrive and read on flush;
   // a read always comes after the write of the same entry
   mdte_ram #(
      .WIDTH (8),
      .DEPTH (mdte_pkg::DEL_DEPTH)
   ) u_del_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // holds back one result so the last of an item can take its marks,
   // then feeds the output register; the next item is taken while it waits
   mdte_obuf u_obuf (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp_ch)
   );

endmodule

@@ test/md_tag_event_encoder_top_tb.sv @@
// self-checking testbench of the md tag event encoder: tag characters in, event bytes checked out
// depends on mdte_pkg, mdte_req_if, mdte_rsp_if and md_tag_event_encoder_top
`timescale 1ns / 1ps

module md_tag_event_encoder_top_tb;

   // run shape
   localparam int RANDOM_CHARS  = 140;
   localparam int HOLD_AT       = 60;        // items accepted before the long receiver hold
   localparam int HOLD_CYCLES   = 500;
   localparam int DRAIN_CYCLES  = 64;        // quiet time after the last expected byte
   localparam int CYCLE_LIMIT   = 4000000;

   // one character of a tag as it is offered on the input channel
   typedef struct packed {
      logic [7:0] ch;
      logic       is_last;
   } tag_char_type;

   // one byte of the encoded payload with its status fields
   typedef struct packed {
      logic [7:0]        out_byte;
      logic              run_last;
      logic              string_done;
      mdte_pkg::err_type error_code;
      logic [15:0]       event_total;
      logic [15:0]       payload_total;
   } md_result_type;

   logic clock = 1'b0;
   logic reset;

   mdte_req_if req_ch ();
   mdte_rsp_if rsp_ch ();

   md_tag_event_encoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stimulus and expectation stores
   tag_char_type  char_queue [$];
   logic [7:0]    tag_buf [$];
   md_result_type pending_bytes [$];
   md_result_type step_out [$];
   string         bad_letters = "EFIJLOPQUXZejoqx";

   // encoder state as the predictor sees it
   mdte_pkg::mode_type enc_mode;
   logic [31:0] run_value;
   logic [3:0]  del_base [mdte_pkg::MAX_DELETION_BASES];
   int          del_count;
   bit          del_has_bad;
   int          ev_count;
   int          pay_count;
   bit          skip_rest;

   // run bookkeeping
   int chars_taken = 0;
   int quiet_from  = 0;
   int total_chars = 0;
   int fail_count  = 0;
   int results_seen = 0;
   int cycle_count = 0;
   int gap_left, stall_left, hold_left;
   bit hold_started;
   tag_char_type next_char;
   md_result_type want;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic void clear_string();
      enc_mode    = mdte_pkg::MODE_IDLE;
      run_value   = '0;
      del_count   = 0;
      del_has_bad = 1'b0;
      ev_count    = 0;
      pay_count   = 0;
   endfunction

   // appends one result for this character, up to the result cap; payload bytes also bump the byte count
   function automatic void emit(input logic [7:0] b, input bit counted);
      md_result_type r;
      if (step_out.size() < mdte_pkg::RESULT_CAP) begin
         r = '0;
         r.out_byte = b;
         step_out.insert(step_out.size(), r);
      end
      if (counted && pay_count < mdte_pkg::BYTE_SAT) begin
         pay_count++;
      end
   endfunction

   // the closing result of a tag carries the code and the totals
   function automatic void mark_done(input mdte_pkg::err_type code);
      md_result_type r;
      if (step_out.size() == 0) begin
         return;
      end
      r = step_out[step_out.size() - 1];
      r.string_done   = 1'b1;
      r.error_code    = code;
      r.event_total   = ev_count[15:0];
      r.payload_total = (pay_count > 65535) ? 16'hFFFF : pay_count[15:0];
      step_out[step_out.size() - 1] = r;
   endfunction

   function automatic bit take_event();
      if (ev_count >= mdte_pkg::EVENT_MAX) begin
         return 1'b0;
      end
      ev_count++;
      return 1'b1;
   endfunction

   // digit run: type byte then the 32-bit value, little endian
   function automatic mdte_pkg::err_type flush_run();
      if (!take_event()) begin
         return mdte_pkg::ERR_COUNT_OVF;
      end
      emit(mdte_pkg::EV_MATCH, 1'b1);
      emit(run_value[7:0], 1'b1);
      emit(run_value[15:8], 1'b1);
      emit(run_value[23:16], 1'b1);
      emit(run_value[31:24], 1'b1);
      enc_mode = mdte_pkg::MODE_IDLE;
      return mdte_pkg::ERR_OK;
   endfunction

   // deletion: type byte, 16-bit length, codes two per byte with the first one high
   function automatic mdte_pkg::err_type flush_del();
      if (del_count == 0) begin
         return mdte_pkg::ERR_DEL_LEN;
      end
      if (del_has_bad) begin
         return mdte_pkg::ERR_DEL_BASE;
      end
      if (!take_event()) begin
         return mdte_pkg::ERR_COUNT_OVF;
      end
      emit(mdte_pkg::EV_DELETION, 1'b1);
      emit(8'(del_count), 1'b1);
      emit(8'(del_count >> 8), 1'b1);
      for (int i = 0; i < del_count; i += 2) begin
         emit({del_base[i], (i + 1 < del_count) ? del_base[i + 1] : 4'h0}, 1'b1);
      end
      enc_mode  = mdte_pkg::MODE_IDLE;
      del_count = 0;
      return mdte_pkg::ERR_OK;
   endfunction

   function automatic mdte_pkg::err_type flush_open();
      if (enc_mode == mdte_pkg::MODE_MATCH) begin
         return flush_run();
      end
      if (enc_mode == mdte_pkg::MODE_DELETION) begin
         return flush_del();
      end
      return mdte_pkg::ERR_OK;
   endfunction

   // works out every result one accepted character causes and queues them
   function automatic void encode_char(input logic [7:0] c, input logic is_last);
      mdte_pkg::err_type err;
      logic [4:0]    code;
      logic [7:0]    up;
      logic [35:0]   grown;
      md_result_type r;
      err = mdte_pkg::ERR_OK;
      step_out.delete();

      // after an error everything up to the end of the tag is dropped silently
      if (skip_rest) begin
         if (is_last) begin
            skip_rest = 1'b0;
            clear_string();
         end
         return;
      end

      if (c >= mdte_pkg::ASCII_0 && c <= mdte_pkg::ASCII_9) begin
         if (enc_mode == mdte_pkg::MODE_DELETION) begin
            err = flush_del();
         end
         if (err == mdte_pkg::ERR_OK) begin
            if (enc_mode != mdte_pkg::MODE_MATCH) begin
               enc_mode  = mdte_pkg::MODE_MATCH;
               run_value = '0;
            end
            grown = {4'b0, run_value} * 36'd10 + {28'b0, c - mdte_pkg::ASCII_0};
            if (grown > 36'hFFFFFFFF) begin
               err = mdte_pkg::ERR_MATCH_OVF;
            end else begin
               run_value = grown[31:0];
            end
         end
      end else if (c == mdte_pkg::ASCII_CARET) begin
         err = flush_open();
         if (err == mdte_pkg::ERR_OK) begin
            enc_mode    = mdte_pkg::MODE_DELETION;
            del_count   = 0;
            del_has_bad = 1'b0;
         end
      end else if ((c >= mdte_pkg::ASCII_UPPER_A && c <= mdte_pkg::ASCII_UPPER_Z) ||
                   (c >= mdte_pkg::ASCII_LOWER_A && c <= mdte_pkg::ASCII_LOWER_Z)) begin
         // table lookup on the upper-case form, 16 when the letter is not a base
         up = (c >= mdte_pkg::ASCII_LOWER_A) ? (c & 8'hDF) : c;
         code = mdte_pkg::CODE_NONE;
         for (int k = 0; k < 16; k++) begin
            if (mdte_pkg::CODE_TABLE[k] == up) begin
               code = 5'(k);
            end
         end
         if (enc_mode == mdte_pkg::MODE_DELETION) begin
            if (del_count >= mdte_pkg::MAX_DELETION_BASES) begin
               err = mdte_pkg::ERR_DEL_LEN;
            end else begin
               if (code == mdte_pkg::CODE_NONE) begin
                  del_has_bad = 1'b1;
                  code = '0;
               end
               del_base[del_count] = code[3:0];
               del_count++;
            end
         end else begin
            if (enc_mode == mdte_pkg::MODE_MATCH) begin
               err = flush_run();
            end
            if (err == mdte_pkg::ERR_OK) begin
               if (code == mdte_pkg::CODE_NONE) begin
                  err = mdte_pkg::ERR_MIS_BASE;
               end else if (!take_event()) begin
                  err = mdte_pkg::ERR_COUNT_OVF;
               end else begin
                  emit(mdte_pkg::EV_MISMATCH, 1'b1);
                  emit({4'b0, code[3:0]}, 1'b1);
               end
            end
         end
      end else begin
         err = mdte_pkg::ERR_BAD_CHAR;
      end

      // end of tag: close the open event and mark the final byte
      if (err == mdte_pkg::ERR_OK && is_last) begin
         err = flush_open();
         if (err == mdte_pkg::ERR_OK) begin
            if (step_out.size() == 0) begin
               emit(8'h00, 1'b0);
            end
            mark_done((pay_count > 65535) ? mdte_pkg::ERR_PAYLOAD_OVF : mdte_pkg::ERR_OK);
            clear_string();
         end
      end

      // an error adds its own closing result and starts discarding
      if (err != mdte_pkg::ERR_OK) begin
         emit(8'h00, 1'b0);
         mark_done(err);
         clear_string();
         skip_rest = !is_last;
      end

      if (step_out.size() > 0) begin
         r = step_out[step_out.size() - 1];
         r.run_last = 1'b1;
         step_out[step_out.size() - 1] = r;
      end
      foreach (step_out[i]) begin
         pending_bytes.insert(pending_bytes.size(), step_out[i]);
      end
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // random iupac base from the table, sometimes in lower case
   function automatic logic [7:0] good_letter();
      logic [7:0] c;
      c = mdte_pkg::CODE_TABLE[$urandom_range(1, 15)];
      if ($urandom_range(0, 2) == 0) begin
         c = c | mdte_pkg::ASCII_CASE;
      end
      return c;
   endfunction

   // appends one character to the tag being built
   function automatic void put_char(input logic [7:0] c);
      tag_buf.insert(tag_buf.size(), c);
   endfunction

   // moves the built tag to the input queue, last flag on its final character
   function automatic void close_tag();
      tag_char_type tc;
      foreach (tag_buf[i]) begin
         tc.ch      = tag_buf[i];
         tc.is_last = (i == tag_buf.size() - 1);
         char_queue.insert(char_queue.size(), tc);
      end
      tag_buf.delete();
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         put_char(s[i]);
      end
      close_tag();
   endfunction

   // mismatch report: one line each, and the count
   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      $display("[%0t] result %0d: %s is %0h, predicted %0h",
               $time, results_seen, what, got, exp_val);
      fail_count++;
   endtask

   // ---------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------

   initial begin
      int n_tok;
      int pick;
      int len;

      reset = 1'b1;

      // directed tags: plain events, lower case, odd deletion and the deletion, base and character error paths
      add_text("7");
      add_text("a");
      add_text("^gT");
      add_text("^");          // empty deletion closed by the end of the tag
      add_text("^1");         // empty deletion closed by a digit
      add_text("^AX");        // non-base letter inside a deletion
      add_text("X3");         // non-base mismatch, the rest is discarded
      put_char(8'h00);
      put_char(8'hFF);
      close_tag();            // bad character then a discarded all-ones byte
      add_text("=");          // table entry that is not a letter
      add_text("3C^T2");
      put_char(8'hFF);
      close_tag();

      // random tags: mostly well-formed md strings with some noise mixed in
      len = char_queue.size();
      while (char_queue.size() - len < RANDOM_CHARS) begin
         n_tok = $urandom_range(1, 8);
         for (int t = 0; t < n_tok; t++) begin
            pick = $urandom_range(0, 39);
            if (pick < 2) begin
               put_char(8'($urandom_range(0, 255)));
            end else if (pick < 4) begin
               put_char(bad_letters[$urandom_range(0, 15)]);
            end else if (pick < 16) begin
               // match run, now and then long enough to overflow 32 bits
               repeat ((pick == 15) ? $urandom_range(9, 11) : $urandom_range(1, 3)) begin
                  put_char(8'(mdte_pkg::ASCII_0 + $urandom_range(0, 9)));
               end
            end else if (pick < 27) begin
               put_char(good_letter());
            end else begin
               // deletion run, rarely empty or near the buffer size
               put_char(mdte_pkg::ASCII_CARET);
               repeat ((pick == 39) ? $urandom_range(20, 65) :
                       (pick == 38) ? 0 : $urandom_range(1, 6)) begin
                  put_char(($urandom_range(0, 29) == 0) ?
                           bad_letters[$urandom_range(0, 15)] : good_letter());
               end
               if ($urandom_range(0, 3) != 0) begin
                  put_char(8'(mdte_pkg::ASCII_0 + $urandom_range(0, 9)));
               end
            end
         end
         close_tag();
      end
      quiet_from = char_queue.size();

      // long tags, run without idling
      add_text("4294967295");  // largest match length
      add_text("4294967296");  // one past it
      // full deletion buffer flushed by a digit that also ends the tag: 40 results
      put_char(mdte_pkg::ASCII_CARET);
      repeat (mdte_pkg::MAX_DELETION_BASES) put_char(good_letter());
      put_char(8'(mdte_pkg::ASCII_0 + $urandom_range(0, 9)));
      close_tag();
      // one base too many in a deletion
      put_char(mdte_pkg::ASCII_CARET);
      repeat (mdte_pkg::MAX_DELETION_BASES + 1) put_char(good_letter());
      put_char(8'(mdte_pkg::ASCII_0 + $urandom_range(0, 9)));
      close_tag();
      add_text("12g");         // clean tag after the error tags
      total_chars = char_queue.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (chars_taken < total_chars) @(posedge clock);
      while (pending_bytes.size() != 0) @(posedge clock);
      // give a stray extra result time to show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_bytes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // input driver: offers queued characters, predicts each accepted one
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.char_in <= 8'h00;
         req_ch.last_char <= 1'b0;
         gap_left <= 0;
         clear_string();
         skip_rest = 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         // the character on the bus is taken at this edge
         if (req_ch.valid) begin
            encode_char(req_ch.char_in, req_ch.last_char);
            chars_taken <= chars_taken + 1;
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (char_queue.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (chars_taken < quiet_from && $urandom_range(0, 9) == 0) begin
            // random idle burst
            gap_left <= $urandom_range(0, 13);
            req_ch.valid <= 1'b0;
         end else begin
            next_char = char_queue.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.char_in <= next_char.ch;
            req_ch.last_char <= next_char.is_last;
         end
      end
   end

   // ---------------------------------------------------------------
   // result side: random stalls plus one long hold
   // ---------------------------------------------------------------

   // long hold, counted here while the sender keeps offering items
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_started <= 1'b0;
      end else if (!hold_started && chars_taken >= HOLD_AT) begin
         hold_started <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
      end else if (chars_taken < quiet_from && $urandom_range(0, 7) == 0) begin
         // random stall burst
         stall_left <= $urandom_range(0, 13);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor: every accepted byte against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("unpredicted result, out_byte", rsp_ch.out_byte, 0);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_ch.out_byte !== want.out_byte) begin
               report_mismatch("out_byte", rsp_ch.out_byte, want.out_byte);
            end
            if (rsp_ch.run_last !== want.run_last) begin
               report_mismatch("run_last", rsp_ch.run_last, want.run_last);
            end
            if (rsp_ch.string_done !== want.string_done) begin
               report_mismatch("string_done", rsp_ch.string_done, want.string_done);
            end
            if (rsp_ch.error_code !== want.error_code) begin
               report_mismatch("error_code", rsp_ch.error_code, want.error_code);
            end
            if (rsp_ch.event_total !== want.event_total) begin
               report_mismatch("event_total", rsp_ch.event_total, want.event_total);
            end
            if (rsp_ch.payload_total !== want.payload_total) begin
               report_mismatch("payload_total", rsp_ch.payload_total, want.payload_total);
            end
         end
         results_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
